// ===== design/pwsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pwsfr_pkg
// Shared types and constants for the pulse width sensor frame receiver.
// ----------------------------------------------------------------------------
package pwsfr_pkg;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX = 8'd3;

  // Window reset values
  localparam logic [7:0] ONE_MIN_RST  = 8'd17;
  localparam logic [7:0] ONE_MAX_RST  = 8'd25;
  localparam logic [7:0] ZERO_MIN_RST = 8'd55;
  localparam logic [7:0] ZERO_MAX_RST = 8'd70;

  // Pulse classification codes
  localparam logic [1:0] KIND_ONE     = 2'd0;
  localparam logic [1:0] KIND_ZERO    = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  // Frame layout
  localparam int unsigned FRAME_LEN = 5;
  localparam logic [2:0]  FRAME_LAST_IDX = 3'd4;
  localparam logic [2:0]  CRC_BYTES = 3'd4;
  localparam logic [7:0]  CRC_POLY = 8'h31;
  localparam logic [2:0]  HIST_PRESET = 3'b111;
  localparam logic [2:0]  PREAMBLE = 3'b110;

  // Receiver phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HUNT    = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  // Classification windows
  typedef struct packed {
    logic [7:0] one_min;
    logic [7:0] one_max;
    logic [7:0] zero_min;
    logic [7:0] zero_max;
  } win_cfg_t;

  // One result word
  typedef struct packed {
    logic [1:0]         pulse_kind;
    logic               frame_done;
    logic               crc_ok;
    logic [11:0]        sensor_id;
    logic signed [11:0] temperature;
    logic [7:0]         humidity;
    logic [7:0]         crc_calc;
    logic [7:0]         crc_recv;
  } result_t;

endpackage

// ===== design/pwsfr_decoder.sv =====
// ----------------------------------------------------------------------------
// pwsfr_decoder
// Pulse classifier, preamble hunt and frame assembly with a running CRC-8.
// ----------------------------------------------------------------------------
module pwsfr_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  pwsfr_pkg::win_cfg_t win,
  input  logic [7:0]         pulse_width,
  output pwsfr_pkg::result_t res
);
  import pwsfr_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [2:0] hist_r, hist_nxt;
  logic [2:0] byte_idx_r, byte_idx_nxt;
  logic [2:0] bit_idx_r, bit_idx_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] frame_r [FRAME_LEN];
  logic [7:0] frame_nxt [FRAME_LEN];

  logic       is_one, is_zero, sample;
  logic [2:0] hist_base, hist_shift;
  logic [10:0] mag;

  // One bit of CRC-8, MSB first
  function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic din);
    logic mix;
    mix = crc[7] ^ din;
    return {crc[6:0], 1'b0} ^ (mix ? CRC_POLY : 8'h00);
  endfunction

  // Inclusive windows; the one window wins where they overlap
  assign is_one  = (pulse_width >= win.one_min) && (pulse_width <= win.one_max);
  assign is_zero = (pulse_width >= win.zero_min) && (pulse_width <= win.zero_max);
  assign sample  = is_one;

  // From idle the history is preset before the shift
  assign hist_base  = (phase_r == PH_HUNT) ? hist_r : HIST_PRESET;
  assign hist_shift = {hist_base[1:0], sample};

  // Next state and result
  always_comb begin
    phase_nxt    = phase_r;
    hist_nxt     = hist_r;
    byte_idx_nxt = byte_idx_r;
    bit_idx_nxt  = bit_idx_r;
    crc_nxt      = crc_r;
    for (int i = 0; i < FRAME_LEN; i++) begin
      frame_nxt[i] = frame_r[i];
    end
    res = '0;
    mag = '0;

    if (!(is_one || is_zero)) begin
      res.pulse_kind = KIND_INVALID;
      phase_nxt      = PH_IDLE;
    end else begin
      res.pulse_kind = is_one ? KIND_ONE : KIND_ZERO;
      case (phase_r)
        PH_COLLECT: begin
          if (byte_idx_r <= FRAME_LAST_IDX) begin
            frame_nxt[byte_idx_r] = {frame_r[byte_idx_r][6:0], sample};
          end
          if (byte_idx_r < CRC_BYTES) begin
            crc_nxt = crc_bit(crc_r, sample);
          end
          bit_idx_nxt = bit_idx_r + 3'd1;
          if (bit_idx_nxt == 3'd0) begin
            byte_idx_nxt = byte_idx_r + 3'd1;
          end
          if (byte_idx_nxt > FRAME_LAST_IDX) begin
            phase_nxt       = PH_IDLE;
            mag             = {frame_nxt[1][2:0], frame_nxt[2]};
            res.frame_done  = 1'b1;
            res.crc_calc    = crc_nxt;
            res.crc_recv    = frame_nxt[4];
            res.crc_ok      = (crc_nxt == frame_nxt[4]);
            res.sensor_id   = {frame_nxt[0], frame_nxt[1][7:4]};
            res.temperature = frame_nxt[1][3] ? -$signed({1'b0, mag})
                                              : $signed({1'b0, mag});
            res.humidity    = frame_nxt[3];
          end
        end
        default: begin
          // Idle or hunting: shift history, look for the preamble
          hist_nxt  = hist_shift;
          phase_nxt = PH_HUNT;
          if (hist_shift == PREAMBLE) begin
            byte_idx_nxt = 3'd0;
            bit_idx_nxt  = 3'd1;
            crc_nxt      = 8'h00;
            for (int i = 0; i < FRAME_LEN; i++) begin
              frame_nxt[i] = 8'h00;
            end
            phase_nxt = PH_COLLECT;
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      hist_r     <= HIST_PRESET;
      byte_idx_r <= 3'd0;
      bit_idx_r  <= 3'd0;
      crc_r      <= 8'h00;
      for (int i = 0; i < FRAME_LEN; i++) begin
        frame_r[i] <= 8'h00;
      end
    end else if (step) begin
      phase_r    <= phase_nxt;
      hist_r     <= hist_nxt;
      byte_idx_r <= byte_idx_nxt;
      bit_idx_r  <= bit_idx_nxt;
      crc_r      <= crc_nxt;
      for (int i = 0; i < FRAME_LEN; i++) begin
        frame_r[i] <= frame_nxt[i];
      end
    end
  end

`ifndef SYNTHESIS
  // Collecting always has a byte slot to fill
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COLLECT |-> byte_idx_r <= FRAME_LAST_IDX)
    else $error("byte index past frame while collecting");
  // A finished frame drops back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.frame_done |=> phase_r == PH_IDLE)
    else $error("receiver not idle after frame");
  // An invalid pulse always resets the receiver
  a_invalid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.pulse_kind == KIND_INVALID |=> phase_r == PH_IDLE)
    else $error("invalid pulse did not reset receiver");
`endif

endmodule

// ===== design/pulse_width_sensor_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// pulse_width_sensor_frame_receiver_top
// Decodes pulse widths into sensor frames with CRC check.
// ----------------------------------------------------------------------------
// Path: the input register, then the result register, with the decode step
//   between them.
// Throughput: one pulse word per cycle while out_stall is low; set by the single decode step.
// Reset: synchronous active-low rst_n clears both pipeline stages, the
//   receiver state and loads the window registers with their defaults.
module pulse_width_sensor_frame_receiver_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pwsfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_pulse_width,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_pulse_kind,
  output logic                               out_frame_done,
  output logic                               out_crc_ok,
  output logic [11:0]                        out_sensor_id,
  output logic signed [11:0]                 out_temperature,
  output logic [7:0]                         out_humidity,
  output logic [7:0]                         out_crc_calc,
  output logic [7:0]                         out_crc_recv
);
  import pwsfr_pkg::*;

  win_cfg_t   win_r;
  logic       s1_valid_r;
  logic [7:0] s1_width_r;
  logic       out_valid_r;
  result_t    out_r;
  result_t    res;
  logic       advance;

  assign cfg_ready = 1'b1;

  // Window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.one_min  <= ONE_MIN_RST;
      win_r.one_max  <= ONE_MAX_RST;
      win_r.zero_min <= ZERO_MIN_RST;
      win_r.zero_max <= ZERO_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ONE_MIN:  win_r.one_min  <= cfg_data;
        REG_ONE_MAX:  win_r.one_max  <= cfg_data;
        REG_ZERO_MIN: win_r.zero_min <= cfg_data;
        REG_ZERO_MAX: win_r.zero_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1 word moves on when the result register is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_width_r <= in_pulse_width;
    end
  end

  pwsfr_decoder u_decoder (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .win         (win_r),
    .pulse_width (s1_width_r),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pulse_kind  = out_r.pulse_kind;
  assign out_frame_done  = out_r.frame_done;
  assign out_crc_ok      = out_r.crc_ok;
  assign out_sensor_id   = out_r.sensor_id;
  assign out_temperature = out_r.temperature;
  assign out_humidity    = out_r.humidity;
  assign out_crc_calc    = out_r.crc_calc;
  assign out_crc_recv    = out_r.crc_recv;

`ifndef SYNTHESIS
  // A completed frame comes only from a valid bit
  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_pulse_kind != KIND_INVALID)
    else $error("frame completed on invalid pulse");
  // Without a frame the frame fields are cleared
  a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |-> !out_crc_ok && out_sensor_id == 12'd0 &&
      out_temperature == 12'sd0 && out_humidity == 8'd0 &&
      out_crc_calc == 8'd0 && out_crc_recv == 8'd0)
    else $error("frame fields set without frame");
  // The stall only rises with both stages full and the output held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a full pipeline");
`endif

endmodule
